/* sv/nbody_gravity_step_2d_macros.svh */
// Assertion macros shared by the gravity step checker.
// No dependencies; include by bare file name.
`ifndef NBODY_GRAVITY_STEP_2D_MACROS_SVH
`define NBODY_GRAVITY_STEP_2D_MACROS_SVH

// same-cycle implication
`define NGS_AST_IMP(lbl, ck, rn, pre, post, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (pre) |-> (post)) else $error(msg);

// next-cycle implication
`define NGS_AST_NXT(lbl, ck, rn, pre, post, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (pre) |=> (post)) else $error(msg);

`endif

/* sv/ngs_pkg.sv */
// Types, codes and fixed-point helpers for the gravity step block.
// No dependencies.
`default_nettype none
package ngs_pkg;

  localparam logic [1:0] FUNC_LOAD = 2'd0;
  localparam logic [1:0] FUNC_STEP = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;
  localparam logic [1:0] FUNC_NOP  = 2'd3;

  localparam int IN_TDATA_W  = 160;
  localparam int OUT_TDATA_W = 176;
  localparam int RED_LSB     = 154;
  localparam int BLUE_LSB    = 162;

  localparam logic [10:0] ACTIVE_RESET = 11'd1024;
  localparam logic [47:0] G_CAP = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_MIN = 32'h8000_0000;
  localparam logic [7:0]  LEVEL_MAX = 8'd255;
  localparam logic [3:0]  COLOUR_GAIN = 4'd10;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RDI, ST_LDI, ST_RDJ, ST_LDJ, ST_RDR, ST_LDR,
    ST_SQX, ST_SQY, ST_CHK, ST_SQRT, ST_DIVS, ST_DIVW,
    ST_MUL, ST_ACC, ST_WRJ, ST_WRI, ST_OUT
  } ngs_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ngs_unit_stat_t;

  function automatic logic [31:0] sat34(input logic [33:0] s);
    logic [31:0] r;
    if (s[33:31] == 3'b000 || s[33:31] == 3'b111) r = s[31:0];
    else if (s[33]) r = SAT_MIN;
    else r = SAT_MAX;
    return r;
  endfunction

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [33:0] s;
    s = {{2{a[31]}}, a} + {{2{b[31]}}, b};
    return sat34(s);
  endfunction

  function automatic logic [31:0] sat_sub(input logic [31:0] a, input logic [31:0] b);
    logic [33:0] s;
    s = {{2{a[31]}}, a} - {{2{b[31]}}, b};
    return sat34(s);
  endfunction

  function automatic logic [31:0] mag32(input logic [31:0] v);
    logic [31:0] r;
    r = v[31] ? (~v + 32'd1) : v;
    return r;
  endfunction

endpackage
`default_nettype wire

/* sv/ngs_ram.sv */
// Simple dual-port synchronous RAM, registered read.
// No dependencies.
`default_nettype none
module ngs_ram #(
  parameter int W = 32,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* sv/ngs_isqrt.sv */
// Iterative 64-bit integer square root, two radicand bits per cycle.
// Depends on ngs_pkg.
`default_nettype none
module ngs_isqrt
  import ngs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] val,
  output logic      [31:0] res,
  output ngs_unit_stat_t   stat
);

  logic [63:0] v_r, r_r, bit_r;
  logic [4:0]  cnt_r;
  logic        busy_r, done_r;
  logic [63:0] t;

  assign t = r_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == 5'd31) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r   <= val;
      r_r   <= 64'd0;
      bit_r <= 64'd1 << 62;
      cnt_r <= 5'd0;
    end else if (busy_r) begin
      if (v_r >= t) begin
        v_r <= v_r - t;
        r_r <= (r_r >> 1) + bit_r;
      end else begin
        r_r <= r_r >> 1;
      end
      bit_r <= bit_r >> 2;
      cnt_r <= cnt_r + 5'd1;
    end
  end

  assign res  = r_r[31:0];
  assign stat = '{busy: busy_r, done: done_r};

endmodule
`default_nettype wire

/* sv/ngs_div.sv */
// Restoring 64-by-64 unsigned divider, one quotient bit per cycle.
// Depends on ngs_pkg.
`default_nettype none
module ngs_div
  import ngs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] num,
  input  wire logic [63:0] den,
  output logic      [63:0] quo,
  output ngs_unit_stat_t   stat
);

  localparam int STEPS = 64;
  localparam int CNTW = $clog2(STEPS);

  logic [63:0]     rem_r, quo_r, den_r;
  logic [CNTW-1:0] cnt_r;
  logic            busy_r, done_r;
  logic [64:0]     trial;
  logic            fits;

  assign trial = {rem_r, quo_r[63]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CNTW'(STEPS - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= 64'd0;
      quo_r <= num;
      den_r <= den;
      cnt_r <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? 64'(trial - {1'b0, den_r}) : trial[63:0];
      quo_r <= {quo_r[62:0], fits};
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign quo  = quo_r;
  assign stat = '{busy: busy_r, done: done_r};

endmodule
`default_nettype wire

/* sv/nbody_gravity_step_2d.sv */
// Top level: particle store, pair sequencer and shared arithmetic units.
// Depends on ngs_pkg, ngs_ram, ngs_isqrt, ngs_div.
//
//  channel | handshake              | payload
//  in      | in_tvalid / in_tready  | in_tuser func, in_tdata particle fields
//  out     | out_tvalid / out_tready| out_tdata particle, speed colour
//  cfg     | cfg_we                 | cfg_wdata active_count
//
// Load: written to the store as it is accepted. Read: the result follows the
// 32-step square root. Step: visits every pair once; each non-coincident pair takes
// four quotients on the shared divider, while coincident pairs skip the root and divider.
// Reset leaves the store undefined; no clearing pass.
// A finished read waits in the output register; a new read stalls only at delivery.
`default_nettype none
module nbody_gravity_step_2d
  import ngs_pkg::*;
#(
  parameter int MAX_PARTICLES = 1024
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // func
  input  wire logic [1:0]             in_tuser,
  // particle_index, in_pos_x, in_pos_y, in_vel_x, in_vel_y, in_mass
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // out_index, out_pos_x, out_pos_y, out_vel_x, out_vel_y, out_mass, red, blue
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  input  wire logic                   cfg_we,
  input  wire logic [10:0]            cfg_wdata
);

  localparam int AW = $clog2(MAX_PARTICLES);
  localparam int CW = $clog2(MAX_PARTICLES + 1);

  ngs_state_t state_r, state_nxt;

  logic [10:0]   act_r;
  logic [CW-1:0] n_r, i_r, j_r, n_clamp;
  logic [AW-1:0] idx_r;
  logic          rd_mode_r;
  logic [31:0]   pxi_r, pyi_r, vxi_r, vyi_r, vxj_r, vyj_r;
  logic [15:0]   mi_r, mj_r;
  logic          dxneg_r, dyneg_r;
  logic [31:0]   ax_r, ay_r, d_r;
  logic [63:0]   sq_r, prod_r;
  logic [47:0]   gi_r, gj_r;
  logic [16:0]   ux_r, uy_r;
  logic [1:0]    dk_r, k_r;
  logic          out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic [9:0]  in_idx;
  logic [31:0] in_px, in_py, in_vx, in_vy;
  logic [15:0] in_m;
  logic        in_acc, idx_ok;

  logic          ram_we_pos, ram_we_vel, ram_we_m;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]   w_px, w_py, w_vx, w_vy;
  logic [31:0]   rd_px, rd_py, rd_vx, rd_vy;
  logic [15:0]   rd_m;

  logic           sqrt_start, div_start;
  logic [31:0]    sqrt_res;
  ngs_unit_stat_t sqrt_stat, div_stat;
  logic [63:0]    div_num, div_den, div_quo;

  logic [31:0]   diff_x, diff_y, pull;
  logic [47:0]   p_mag, g_sel, g_cap;
  logic [16:0]   u_sel;
  logic          p_neg;
  logic [35:0]   speed10;
  logic [7:0]    red, blue;
  logic          out_free;

  assign in_idx = in_tdata[9:0];
  assign in_px  = in_tdata[41:10];
  assign in_py  = in_tdata[73:42];
  assign in_vx  = in_tdata[105:74];
  assign in_vy  = in_tdata[137:106];
  assign in_m   = in_tdata[153:138];
  assign in_acc = in_tvalid && in_tready;
  assign idx_ok = {22'd0, in_idx} < 32'(MAX_PARTICLES);
  assign n_clamp = ({21'd0, act_r} > 32'(MAX_PARTICLES)) ? CW'(MAX_PARTICLES) : CW'(act_r);
  assign out_free = !out_valid_r || out_tready;

  ngs_ram #(.W(32), .DEPTH(MAX_PARTICLES)) u_px (
    .clk(clk), .we(ram_we_pos), .waddr(ram_waddr), .wdata(w_px),
    .raddr(ram_raddr), .rdata(rd_px));
  ngs_ram #(.W(32), .DEPTH(MAX_PARTICLES)) u_py (
    .clk(clk), .we(ram_we_pos), .waddr(ram_waddr), .wdata(w_py),
    .raddr(ram_raddr), .rdata(rd_py));
  ngs_ram #(.W(32), .DEPTH(MAX_PARTICLES)) u_vx (
    .clk(clk), .we(ram_we_vel), .waddr(ram_waddr), .wdata(w_vx),
    .raddr(ram_raddr), .rdata(rd_vx));
  ngs_ram #(.W(32), .DEPTH(MAX_PARTICLES)) u_vy (
    .clk(clk), .we(ram_we_vel), .waddr(ram_waddr), .wdata(w_vy),
    .raddr(ram_raddr), .rdata(rd_vy));
  ngs_ram #(.W(16), .DEPTH(MAX_PARTICLES)) u_m (
    .clk(clk), .we(ram_we_m), .waddr(ram_waddr), .wdata(in_m),
    .raddr(ram_raddr), .rdata(rd_m));

  ngs_isqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sqrt_start), .val(sq_r),
    .res(sqrt_res), .stat(sqrt_stat));

  ngs_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
    .quo(div_quo), .stat(div_stat));

  always_comb begin
    case (dk_r)
      2'd0: begin div_num = {mj_r, 48'd0}; div_den = sq_r; end
      2'd1: begin div_num = {mi_r, 48'd0}; div_den = sq_r; end
      2'd2: begin div_num = {16'd0, ax_r, 16'd0}; div_den = {32'd0, d_r}; end
      default: begin div_num = {16'd0, ay_r, 16'd0}; div_den = {32'd0, d_r}; end
    endcase
  end
  assign g_cap = (|div_quo[63:48]) ? G_CAP : div_quo[47:0];

  assign diff_x = sat_sub(rd_px, pxi_r);
  assign diff_y = sat_sub(rd_py, pyi_r);

  assign g_sel = k_r[1] ? gj_r : gi_r;
  assign u_sel = k_r[0] ? uy_r : ux_r;
  assign p_neg = k_r[0] ? dyneg_r : dxneg_r;
  assign p_mag = prod_r[63:16];
  always_comb begin
    if (p_neg) begin
      pull = (|p_mag[47:32] || (p_mag[31] && |p_mag[30:0])) ? SAT_MIN
                                                           : (~p_mag[31:0] + 32'd1);
    end else begin
      pull = (|p_mag[47:31]) ? SAT_MAX : p_mag[31:0];
    end
  end

  assign speed10 = {4'd0, d_r} * {32'd0, COLOUR_GAIN};
  assign red  = (|speed10[35:24]) ? LEVEL_MAX : speed10[23:16];
  assign blue = LEVEL_MAX - red;

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    in_tready  = 1'b0;
    ram_we_pos = 1'b0;
    ram_we_vel = 1'b0;
    ram_we_m   = 1'b0;
    ram_waddr  = AW'(i_r);
    ram_raddr  = AW'(i_r);
    w_px = sat_add(pxi_r, vxi_r);
    w_py = sat_add(pyi_r, vyi_r);
    w_vx = vxi_r;
    w_vy = vyi_r;
    sqrt_start = 1'b0;
    div_start  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        ram_waddr = AW'(in_idx);
        w_px = in_px;
        w_py = in_py;
        w_vx = in_vx;
        w_vy = in_vy;
        if (in_acc) begin
          case (in_tuser)
            FUNC_LOAD: begin
              ram_we_pos = idx_ok;
              ram_we_vel = idx_ok;
              ram_we_m   = idx_ok;
            end
            FUNC_STEP: if (n_clamp != '0) state_nxt = ST_RDI;
            FUNC_READ: if (idx_ok) state_nxt = ST_RDR;
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_RDI: state_nxt = ST_LDI;
      ST_LDI: state_nxt = ST_RDJ;
      ST_RDJ: begin
        ram_raddr = AW'(j_r);
        state_nxt = (j_r >= n_r) ? ST_WRI : ST_LDJ;
      end
      ST_LDJ: state_nxt = ST_SQX;
      ST_RDR: begin
        ram_raddr = idx_r;
        state_nxt = ST_LDR;
      end
      ST_LDR: state_nxt = ST_SQX;
      ST_SQX: state_nxt = ST_SQY;
      ST_SQY: state_nxt = ST_CHK;
      ST_CHK: begin
        if (rd_mode_r || sq_r != 64'd0) begin
          sqrt_start = 1'b1;
          state_nxt  = ST_SQRT;
        end else begin
          state_nxt = ST_RDJ;
        end
      end
      ST_SQRT: if (sqrt_stat.done) state_nxt = rd_mode_r ? ST_OUT : ST_DIVS;
      ST_DIVS: begin
        div_start = 1'b1;
        state_nxt = ST_DIVW;
      end
      ST_DIVW: if (div_stat.done) state_nxt = (dk_r == 2'd3) ? ST_MUL : ST_DIVS;
      ST_MUL: state_nxt = ST_ACC;
      ST_ACC: state_nxt = (k_r == 2'd3) ? ST_WRJ : ST_MUL;
      ST_WRJ: begin
        ram_we_vel = 1'b1;
        ram_waddr  = AW'(j_r);
        w_vx = vxj_r;
        w_vy = vyj_r;
        state_nxt  = ST_RDJ;
      end
      ST_WRI: begin
        ram_we_pos = 1'b1;
        ram_we_vel = 1'b1;
        state_nxt  = (CW'(i_r + 1'b1) == n_r) ? ST_IDLE : ST_RDI;
      end
      ST_OUT: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r       <= ACTIVE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) act_r <= cfg_wdata;
      if (state_r == ST_OUT && out_free) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        idx_r <= AW'(in_idx);
        n_r   <= n_clamp;
        i_r   <= '0;
        rd_mode_r <= (in_tuser == FUNC_READ);
      end
      ST_LDI, ST_LDR: begin
        pxi_r <= rd_px;
        pyi_r <= rd_py;
        vxi_r <= rd_vx;
        vyi_r <= rd_vy;
        mi_r  <= rd_m;
        j_r   <= CW'(i_r + 1'b1);
        ax_r  <= mag32(rd_vx);
        ay_r  <= mag32(rd_vy);
      end
      ST_LDJ: begin
        vxj_r   <= rd_vx;
        vyj_r   <= rd_vy;
        mj_r    <= rd_m;
        dxneg_r <= diff_x[31];
        dyneg_r <= diff_y[31];
        ax_r    <= mag32(diff_x);
        ay_r    <= mag32(diff_y);
      end
      ST_SQX: sq_r <= {32'd0, ax_r} * {32'd0, ax_r};
      ST_SQY: sq_r <= sq_r + {32'd0, ay_r} * {32'd0, ay_r};
      ST_CHK: if (!rd_mode_r && sq_r == 64'd0) j_r <= CW'(j_r + 1'b1);
      ST_SQRT: begin
        d_r  <= sqrt_res;
        dk_r <= 2'd0;
      end
      ST_DIVW: begin
        if (div_stat.done) begin
          case (dk_r)
            2'd0: gi_r <= g_cap;
            2'd1: gj_r <= g_cap;
            2'd2: ux_r <= div_quo[16:0];
            default: uy_r <= div_quo[16:0];
          endcase
          dk_r <= dk_r + 2'd1;
          k_r  <= 2'd0;
        end
      end
      ST_MUL: prod_r <= {16'd0, g_sel} * {47'd0, u_sel};
      ST_ACC: begin
        case (k_r)
          2'd0: vxi_r <= sat_add(vxi_r, pull);
          2'd1: vyi_r <= sat_add(vyi_r, pull);
          2'd2: vxj_r <= sat_sub(vxj_r, pull);
          default: vyj_r <= sat_sub(vyj_r, pull);
        endcase
        k_r <= k_r + 2'd1;
      end
      ST_WRJ: j_r <= CW'(j_r + 1'b1);
      ST_WRI: i_r <= CW'(i_r + 1'b1);
      ST_OUT: begin
        if (out_free) begin
          out_data_r <= {6'd0, blue, red, mi_r, vyi_r, vxi_r, pyi_r, pxi_r, 10'(idx_r)};
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

/* sv/ngs_checker.sv */
// Port-level checks for the gravity step block, bound to the top level.
// Depends on ngs_pkg and nbody_gravity_step_2d_macros.svh.
`default_nettype none
`include "nbody_gravity_step_2d_macros.svh"
module ngs_checker
  import ngs_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tready,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata
);

  `NGS_AST_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")
  `NGS_AST_IMP(a_colour_sum, clk, rst_n, out_tvalid, ({1'b0, out_tdata[BLUE_LSB +: 8]} + {1'b0, out_tdata[RED_LSB +: 8]}) == 9'd255, "red and blue do not sum to full scale")
  `NGS_AST_IMP(a_result_busy, clk, rst_n, $rose(out_tvalid), !$past(in_tready), "result appeared while input side idle")
  `NGS_AST_NXT(a_no_phantom, clk, rst_n, out_tvalid && out_tready, !out_tvalid || !$past(in_tready), "result appeared without a request in flight")

endmodule

bind nbody_gravity_step_2d ngs_checker u_ngs_checker (.*);
`default_nettype wire

/* sim/tb_nbody_gravity_step_2d.sv */
// Testbench for nbody_gravity_step_2d: loads, steps and reads a small particle set.
// A scoreboard class predicts every read result from its own copy of the store.
// Depends on ngs_pkg and the nbody_gravity_step_2d RTL.
`default_nettype none

typedef struct {
  logic [9:0]  idx;
  logic [31:0] px, py, vx, vy;
  logic [15:0] mass;
  logic [7:0]  red, blue;
} particle_rd_t;

class gravity_scoreboard;
  logic [31:0] px[1024], py[1024], vx[1024], vy[1024];
  logic [15:0] mass[1024];
  int unsigned active;
  particle_rd_t expected_q[$];
  int          errors;

  function new();
    active = 1024;
    errors = 0;
  endfunction

  function automatic logic [31:0] sat(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic longint unsigned root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint accel(longint unsigned g, longint comp, longint unsigned d);
    longint unsigned u, p;
    longint          s;
    u = ((comp < 0 ? -comp : comp) << 16) / d;
    p = (g * u) >> 16;
    s = p;
    return longint'($signed(sat(comp < 0 ? -s : s)));
  endfunction

  function automatic longint unsigned gain(logic [15:0] m, longint unsigned d2);
    longint unsigned g;
    g = (longint'(m) << 48) / d2;
    return g > 64'hFFFF_FFFF_FFFF ? 64'hFFFF_FFFF_FFFF : g;
  endfunction

  function void set_active(int unsigned v);
    active = v;
  endfunction

  function int unsigned eff_count();
    return active > 1024 ? 1024 : active;
  endfunction

  function void advance();
    int unsigned n;
    longint dx, dy;
    longint unsigned ax, ay, d2, d, gi, gj;
    n = eff_count();
    for (int i = 0; i < n; i++) begin
      for (int j = i + 1; j < n; j++) begin
        dx = longint'($signed(sat(longint'($signed(px[j])) - longint'($signed(px[i])))));
        dy = longint'($signed(sat(longint'($signed(py[j])) - longint'($signed(py[i])))));
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        d2 = ax * ax + ay * ay;
        if (d2 == 0) continue;
        d  = root(d2);
        gi = gain(mass[j], d2);
        gj = gain(mass[i], d2);
        vx[i] = sat(longint'($signed(vx[i])) + accel(gi, dx, d));
        vy[i] = sat(longint'($signed(vy[i])) + accel(gi, dy, d));
        vx[j] = sat(longint'($signed(vx[j])) - accel(gj, dx, d));
        vy[j] = sat(longint'($signed(vy[j])) - accel(gj, dy, d));
      end
      px[i] = sat(longint'($signed(px[i])) + longint'($signed(vx[i])));
      py[i] = sat(longint'($signed(py[i])) + longint'($signed(vy[i])));
    end
  endfunction

  function void note_request(logic [1:0] func, logic [159:0] data);
    logic [9:0]      idx;
    longint unsigned mx, my, s, r;
    particle_rd_t    e;
    idx = data[9:0];
    case (func)
      ngs_pkg::FUNC_LOAD: begin
        px[idx]   = data[41:10];
        py[idx]   = data[73:42];
        vx[idx]   = data[105:74];
        vy[idx]   = data[137:106];
        mass[idx] = data[153:138];
      end
      ngs_pkg::FUNC_STEP: advance();
      ngs_pkg::FUNC_READ: begin
        mx = longint'($signed(vx[idx]));
        my = longint'($signed(vy[idx]));
        if ($signed(vx[idx]) < 0) mx = -mx;
        if ($signed(vy[idx]) < 0) my = -my;
        s = root(mx * mx + my * my);
        r = (s * 10) >> 16;
        if (r > 255) r = 255;
        e.idx = idx; e.px = px[idx]; e.py = py[idx]; e.vx = vx[idx]; e.vy = vy[idx];
        e.mass = mass[idx]; e.red = r[7:0]; e.blue = 8'd255 - r[7:0];
        expected_q.push_back(e);
      end
      default: ;
    endcase
  endfunction

  function void check_result(logic [175:0] d);
    particle_rd_t e;
    bit           bad;
    if (expected_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result %h", d);
      return;
    end
    e = expected_q.pop_front();
    bad = d[9:0] !== e.idx || d[41:10] !== e.px || d[73:42] !== e.py ||
          d[105:74] !== e.vx || d[137:106] !== e.vy || d[153:138] !== e.mass ||
          d[161:154] !== e.red || d[169:162] !== e.blue;
    if (bad) begin
      errors++;
      if (errors <= 10)
        $display("mismatch slot %0d: exp px %h py %h vx %h vy %h m %h r %h b %h",
                 e.idx, e.px, e.py, e.vx, e.vy, e.mass, e.red, e.blue,
                 "\n  got slot %0d px %h py %h vx %h vy %h m %h r %h b %h",
                 d[9:0], d[41:10], d[73:42], d[105:74], d[137:106], d[153:138],
                 d[161:154], d[169:162]);
    end
  endfunction
endclass

module tb_nbody_gravity_step_2d;
  import ngs_pkg::*;

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [1:0]   in_tuser = 0;
  logic [159:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [175:0] out_tdata;
  logic         cfg_we = 0;
  logic [10:0]  cfg_wdata = '0;
  bit           calm = 0;

  gravity_scoreboard sb = new();

  nbody_gravity_step_2d dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  always @(negedge clk) out_tready <= calm || ($urandom_range(0, 99) >= 29);

  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);

  task automatic send(logic [1:0] func, logic [9:0] idx, logic [31:0] x, logic [31:0] y,
                      logic [31:0] u, logic [31:0] v, logic [15:0] m);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 29) begin
      in_tvalid = 0;
      @(negedge clk);
    end
    in_tuser  = func;
    in_tdata  = {6'd0, m, v, u, y, x, idx};
    in_tvalid = 1;
    do @(posedge clk); while (!in_tready);
    sb.note_request(func, in_tdata);
  endtask

  task automatic load_rand(logic [9:0] idx, bit tame);
    if (tame)
      send(FUNC_LOAD, idx, $urandom_range(0, 32'h3F_FFFF) - 32'h20_0000,
           $urandom_range(0, 32'h3F_FFFF) - 32'h20_0000,
           $urandom_range(0, 32'h3FFF) - 32'h2000, $urandom_range(0, 32'h3FFF) - 32'h2000,
           16'($urandom_range(0, 65535)));
    else
      send(FUNC_LOAD, idx, $urandom, $urandom, $urandom, $urandom,
           16'($urandom_range(0, 65535)));
  endtask

  task automatic pick_read();
    int s;
    s = $urandom_range(0, 7);
    send(FUNC_READ, s[9:0], $urandom, $urandom, $urandom, $urandom,
         16'($urandom_range(0, 65535)));
  endtask

  task automatic drain_and_config(logic [10:0] v);
    @(negedge clk);
    in_tvalid = 0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    while (!in_tready) @(negedge clk);
    cfg_we = 1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 0;
    sb.set_active(v);
  endtask

  int cfg_seq[10] = '{1, 8, 1024, 2, 0, 2047, 6, 3, 7, 5};

  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int r, s;
    repeat (9) @(negedge clk);
    rst_n = 1;
    drain_and_config(11'd4);

    // directed: extremes, zero mass, coincident pair, saturation
    send(FUNC_LOAD, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF);
    send(FUNC_LOAD, 1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF);
    send(FUNC_LOAD, 2, 32'h0001_0000, 32'h0001_0000, 0, 0, 16'd0);
    send(FUNC_LOAD, 3, 32'h0001_0000, 32'h0001_0000, 32'h0000_8000, 32'hFFFF_8000, 16'd5);
    send(FUNC_READ, 0, 0, 0, 0, 0, 0);
    send(FUNC_READ, 1, 0, 0, 0, 0, 0);
    send(FUNC_STEP, 0, 0, 0, 0, 0, 0);
    for (int k = 0; k < 4; k++) send(FUNC_READ, k[9:0], 0, 0, 0, 0, 0);
    send(FUNC_LOAD, 10'd1023, 32'hFFFF_FFFF, 0, 32'h0000_0001, 32'hFFFF_FFFF, 16'h0001);
    send(FUNC_READ, 10'd1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
         16'hFFFF);
    send(FUNC_NOP, 10'h3FF, 0, 0, 0, 0, 0);
    for (int k = 0; k < 8; k++) load_rand(k[9:0], 1);
    send(FUNC_STEP, 0, 0, 0, 0, 0, 0);
    send(FUNC_READ, 2, 0, 0, 0, 0, 0);
    send(FUNC_READ, 3, 0, 0, 0, 0, 0);

    for (int ph = 0; ph < 10; ph++) begin
      drain_and_config(cfg_seq[ph][10:0]);
      calm = (ph == 3);
      for (int k = 0; k < 6; k++) begin
        r = $urandom_range(0, 99);
        if (r < 35) begin
          s = $urandom_range(0, 7);
          load_rand(s[9:0], $urandom_range(0, 99) < 80);
        end else if (r < 45) begin
          s = $urandom_range(8, 1023);
          load_rand(s[9:0], 0);
          send(FUNC_READ, s[9:0], 0, 0, 0, 0, 0);
        end else if (r < 65) begin
          if (sb.eff_count() <= 8) send(FUNC_STEP, 10'($urandom), $urandom, $urandom,
                                        $urandom, $urandom, 16'($urandom_range(0, 65535)));
          else pick_read();
        end else if (r < 92) begin
          pick_read();
        end else begin
          send(FUNC_NOP, 10'($urandom), $urandom, $urandom, $urandom, $urandom,
               16'($urandom_range(0, 65535)));
        end
      end
      pick_read();
      calm = 0;
    end

    @(negedge clk);
    in_tvalid = 0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule

`default_nettype wire

/* nbody_gravity_step_2d.f */
+incdir+sv
sv/ngs_pkg.sv
sv/ngs_ram.sv
sv/ngs_isqrt.sv
sv/ngs_div.sv
sv/nbody_gravity_step_2d.sv
sv/ngs_checker.sv
sim/tb_nbody_gravity_step_2d.sv
